### rtl/bfr_pkg.sv
// Package for the bracket frame receiver: sizes, markers, FSM type, control structs, CRC-8 step.
`default_nettype none

package bfr_pkg;

    // Body storage depth and derived widths
    localparam int MAX_BODY = 32;
    localparam int CNT_W    = $clog2(MAX_BODY + 1);
    localparam int ADDR_W   = $clog2(MAX_BODY);
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;

    // Markers and CRC polynomial
    localparam logic [BYTE_W-1:0] START_MARK = 8'h5B;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'h5D;
    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;

    // Configuration register map
    localparam int          PADDR_W        = 3;
    localparam int          PDATA_W        = 32;
    localparam logic [PADDR_W-1:0] REG_CRC_EN_ADDR = 3'd0;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_BODY,
        ST_AWAIT,
        ST_DECIDE,
        ST_READ,
        ST_LOAD,
        ST_HOLD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;        // frame start: reset count and CRC
        logic store;        // store the received byte
        logic store_end;    // store an end marker as the CRC byte
        logic latch_en;     // capture check enable at frame end
        logic idx_clear;
        logic idx_inc;
        logic load_status;  // load a single status result
        logic load_data;    // load a payload byte result
        logic out_taken;    // output beat accepted
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rx_is_start;
        logic rx_is_end;
        logic single;       // frame yields one status result only
        logic out_valid;
        logic out_last;
    } dp_stat_t;

    // One byte through the CRC-8 register, MSB first
    function automatic logic [BYTE_W-1:0] crc8_add(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1])
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/bfr_datapath.sv
// Datapath: body store, byte count, running CRC, result index and output register.
`default_nettype none

module bfr_datapath
    import bfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic              crc_en,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic [BYTE_W-1:0]      data_byte,
    output logic                   data_valid,
    output logic                   frame_last,
    output logic                   frame_status,
    output logic [LEN_W-1:0]       payload_length,
    output logic                   out_valid
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0] newest_reg, newest_next;
    logic              en_reg, en_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              dvalid_reg, dvalid_next;
    logic              last_reg, last_next;
    logic              status_reg, status_next;
    logic [CNT_W-1:0]  len_reg, len_next;

    logic              wr_en;
    logic [BYTE_W-1:0] wr_byte;
    logic              room;
    logic [BYTE_W-1:0] rd_byte;
    logic              crc_bad;
    logic [CNT_W-1:0]  pay;
    logic              idx_last;

    // Marker detection on the incoming byte
    assign stat.rx_is_start = (rx_byte == START_MARK);
    assign stat.rx_is_end   = (rx_byte == END_MARK);

    // Body write
    assign room    = (count_reg < CNT_W'(MAX_BODY));
    assign wr_byte = cmd.store_end ? END_MARK : rx_byte;
    assign wr_en   = (cmd.store || cmd.store_end) && room;

    bfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_BODY)
    ) u_body_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(wr_byte),
        .raddr(idx_reg),
        .rdata(rd_byte)
    );

    // Frame-end decision; newest byte is the candidate CRC byte
    assign crc_bad  = en_reg && ((count_reg == '0) || (crc_reg != newest_reg));
    assign pay      = en_reg ? (count_reg - CNT_W'(1)) : count_reg;
    assign idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == pay);

    assign stat.single    = crc_bad || (pay == '0);
    assign stat.out_valid = out_valid_reg;
    assign stat.out_last  = last_reg;

    // Count, CRC and newest-byte update
    always_comb
    begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        newest_next = newest_reg;
        en_next     = en_reg;
        idx_next    = idx_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            crc_next   = '0;
        end
        else if (wr_en)
        begin
            if (count_reg != '0)
            begin
                crc_next = crc8_add(crc_reg, newest_reg);
            end
            newest_next = wr_byte;
            count_next  = count_reg + CNT_W'(1);
        end
        if (cmd.latch_en)
        begin
            en_next = crc_en;
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        dvalid_next    = dvalid_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        len_next       = len_reg;
        if (cmd.out_taken)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_status)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            dvalid_next    = 1'b0;
            last_next      = 1'b1;
            status_next    = crc_bad;
            len_next       = '0;
        end
        else if (cmd.load_data)
        begin
            out_valid_next = 1'b1;
            data_next      = rd_byte;
            dvalid_next    = 1'b1;
            last_next      = idx_last;
            status_next    = 1'b0;
            len_next       = pay;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_reg       <= '0;
            en_reg        <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            en_reg        <= en_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        newest_reg <= newest_next;
        data_reg   <= data_next;
        dvalid_reg <= dvalid_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        len_reg    <= len_next;
    end

    assign out_valid      = out_valid_reg;
    assign data_byte      = data_reg;
    assign data_valid     = dvalid_reg;
    assign frame_last     = last_reg;
    assign frame_status   = status_reg;
    assign payload_length = LEN_W'(len_reg);

endmodule

`default_nettype wire

### rtl/bfr_ctrl.sv
// Controller: frame hunt/body/end-marker states and the result read-out sequence.
`default_nettype none

module bfr_ctrl
    import bfr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     more_pending,
    input  wire logic     out_stall,
    input  wire logic     crc_en,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          in_stall
);

    state_t state_reg, state_next;
    logic   in_acc;
    logic   out_acc;

    assign in_stall = !((state_reg == ST_HUNT) || (state_reg == ST_BODY) ||
                        (state_reg == ST_AWAIT));
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = stat.out_valid && !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (in_acc && stat.rx_is_start)
                begin
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (in_acc && stat.rx_is_end)
                begin
                    state_next = (crc_en && more_pending) ? ST_AWAIT : ST_DECIDE;
                end
            end
            ST_AWAIT:
            begin
                if (in_acc)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = stat.single ? ST_HOLD : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_acc)
                begin
                    state_next = stat.out_last ? ST_HUNT : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_HUNT:
            begin
                cmd.clear = in_acc && stat.rx_is_start;
            end
            ST_BODY:
            begin
                cmd.store    = in_acc && !stat.rx_is_end;
                cmd.latch_en = in_acc && stat.rx_is_end && !(crc_en && more_pending);
            end
            ST_AWAIT:
            begin
                cmd.store_end = in_acc && stat.rx_is_end;
                cmd.latch_en  = in_acc;
            end
            ST_DECIDE:
            begin
                cmd.load_status = stat.single;
                cmd.idx_clear   = !stat.single;
            end
            ST_READ:
            begin
                cmd = '0;
            end
            ST_LOAD:
            begin
                cmd.load_data = 1'b1;
            end
            ST_HOLD:
            begin
                cmd.out_taken = out_acc;
                cmd.idx_inc   = out_acc && !stat.out_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bracket_frame_receiver_crc8_check.sv
// Results: after the final beat of a frame is accepted, the decide state loads a
// status-only result, or the read and load states fetch each payload byte, the next
// only after the previous one is taken (body RAM read, output register load).
// Throughput: one input beat per cycle while hunting or inside a frame; input is
// stalled from frame end until the last result beat is taken.
// Reset: rst_n clears control state and the check enable; body RAM is not cleared.
`default_nettype none

module bracket_frame_receiver_crc8_check
    import bfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [BYTE_W-1:0]  rx_byte,
    input  wire logic               more_pending,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [BYTE_W-1:0]       data_byte,
    output logic                    data_valid,
    output logic                    frame_last,
    output logic                    frame_status,
    output logic [LEN_W-1:0]        payload_length
);

    logic     crc_en_reg, crc_en_next;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration register
    assign pready = 1'b1;
    always_comb
    begin
        crc_en_next = crc_en_reg;
        if (psel && penable && pwrite && (paddr == REG_CRC_EN_ADDR))
        begin
            crc_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_en_reg <= 1'b0;
        end
        else
        begin
            crc_en_reg <= crc_en_next;
        end
    end

    assign prdata = (paddr == REG_CRC_EN_ADDR) ? PDATA_W'(crc_en_reg) : '0;

    bfr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .more_pending(more_pending),
        .out_stall   (out_stall),
        .crc_en      (crc_en_reg),
        .stat        (stat),
        .cmd         (cmd),
        .in_stall    (in_stall)
    );

    bfr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .crc_en        (crc_en_reg),
        .rx_byte       (rx_byte),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .frame_last    (frame_last),
        .frame_status  (frame_status),
        .payload_length(payload_length),
        .out_valid     (out_valid)
    );

    // Input is never taken while a result beat is pending
    assert property (@(posedge clk) disable iff (!rst_n) !in_stall |-> !out_valid)
        else $error("input open while result pending");

    // A status-only beat closes the frame with zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_valid) |-> (frame_last && (payload_length == '0)))
        else $error("status beat malformed");

    // An error beat never carries data
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_status) |-> !data_valid)
        else $error("error beat carries data");

    // A payload beat always reports a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && data_valid) |-> (payload_length != '0))
        else $error("payload beat with zero length");

endmodule

`default_nettype wire

### tb/sv/tb_bracket_frame_receiver_crc8_check.sv
// Self-checking testbench for the bracket frame receiver with CRC-8 check.
module tb_bracket_frame_receiver_crc8_check;
    import bfr_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int TARGET_BEATS = 310;

    // One output beat of the block
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic              status;
        logic [LEN_W-1:0]  len;
    } frame_beat_t;

    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_CRC_EN
    } row_kind_t;

    // Directed stimulus row; want is used only where typed is set
    typedef struct packed {
        row_kind_t         kind;
        logic [BYTE_W-1:0] val;
        logic              more;
        logic              typed;
        frame_beat_t       want;
    } script_row_t;

    localparam frame_beat_t NO_BEAT  = '0;
    localparam frame_beat_t EMPTY_OK = '{8'h00, 1'b0, 1'b1, 1'b0, 6'd0};
    localparam frame_beat_t CRC_ERR  = '{8'h00, 1'b0, 1'b1, 1'b1, 6'd0};

    localparam int SCRIPT_LEN = 26;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        // check off: empty frame, extremes, '[' as body byte
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b1, 1'b1, EMPTY_OK},
        '{ROW_BEAT,   START_MARK, 1'b1, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'hFF,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h00,      1'b1, 1'b0, NO_BEAT},
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b0, 1'b0, NO_BEAT},
        // check on
        '{ROW_CRC_EN, 8'h01,      1'b0, 1'b0, NO_BEAT},
        // empty frame is an error
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b0, 1'b1, CRC_ERR},
        // good CRC over one byte
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h31,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h97,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b0, 1'b0, NO_BEAT},
        // CRC mismatch
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h12,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h34,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b0, 1'b1, CRC_ERR},
        // double end marker: first ']' becomes the CRC byte
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h41,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b1, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b0, 1'b0, NO_BEAT},
        // end marker with a pending non-']' byte: byte dropped, CRC alone is good
        '{ROW_BEAT,   START_MARK, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h00,      1'b0, 1'b0, NO_BEAT},
        '{ROW_BEAT,   END_MARK,   1'b1, 1'b0, NO_BEAT},
        '{ROW_BEAT,   8'h7A,      1'b0, 1'b1, EMPTY_OK}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  rx_byte;
    logic               more_pending;
    logic               out_valid;
    logic               out_stall;
    logic [BYTE_W-1:0]  data_byte;
    logic               data_valid;
    logic               frame_last;
    logic               frame_status;
    logic [LEN_W-1:0]   payload_length;

    // Expected output beats, oldest first
    frame_beat_t awaited_beats[$];
    frame_beat_t frame_beats[$];

    // Receiver mirror state
    logic              pr_crc_en;
    logic              pr_in_frame;
    logic              pr_wait_end2;
    int                pr_count;
    logic [BYTE_W-1:0] pr_store [MAX_BODY];
    logic [BYTE_W-1:0] pr_crc;

    int   fail_count;
    int   cycle_count;
    int   useful_beats;
    logic quiet;
    logic hold_req;
    int   hold_left;

    bracket_frame_receiver_crc8_check i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .more_pending   (more_pending),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .frame_last     (frame_last),
        .frame_status   (frame_status),
        .payload_length (payload_length)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // CRC-8, poly 0x07, one input bit per iteration MSB first
    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        logic              fb;
        r = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = r[BYTE_W-1] ^ b[i];
            r  = {r[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
        end
        return r;
    endfunction

    function automatic void keep_body_byte(input logic [BYTE_W-1:0] b);
        if (pr_count < MAX_BODY)
        begin
            // CRC runs one byte behind: the newest byte may be the CRC itself
            if (pr_count > 0)
                pr_crc = crc8_next(pr_crc, pr_store[pr_count-1]);
            pr_store[pr_count] = b;
            pr_count++;
        end
    endfunction

    // Frame end: payload beats or a single status beat
    function automatic void close_frame();
        int          n;
        int          pay;
        frame_beat_t fb;
        n            = pr_count;
        pr_in_frame  = 1'b0;
        pr_wait_end2 = 1'b0;
        pr_count     = 0;
        if (pr_crc_en)
        begin
            if (n == 0 || pr_crc != pr_store[n-1])
            begin
                frame_beats.push_back(CRC_ERR);
                return;
            end
            pay = n - 1;
        end
        else
            pay = n;
        if (pay == 0)
        begin
            frame_beats.push_back(EMPTY_OK);
            return;
        end
        for (int i = 0; i < pay; i++)
        begin
            fb.data   = pr_store[i];
            fb.valid  = 1'b1;
            fb.last   = (i == pay - 1);
            fb.status = 1'b0;
            fb.len    = LEN_W'(pay);
            frame_beats.push_back(fb);
        end
    endfunction

    // Predict the beats caused by one accepted input byte
    function automatic void predict_rx(input logic [BYTE_W-1:0] rx, input logic more);
        frame_beats.delete();
        if (!pr_in_frame)
        begin
            if (rx == START_MARK)
            begin
                pr_in_frame  = 1'b1;
                pr_wait_end2 = 1'b0;
                pr_count     = 0;
                pr_crc       = '0;
            end
            return;
        end
        if (pr_wait_end2)
        begin
            pr_wait_end2 = 1'b0;
            if (rx == END_MARK)
                keep_body_byte(END_MARK);
            close_frame();
            return;
        end
        if (rx != END_MARK)
        begin
            keep_body_byte(rx);
            return;
        end
        if (pr_crc_en && more)
        begin
            pr_wait_end2 = 1'b1;
            return;
        end
        close_frame();
    endfunction

    // Offer one byte and wait until it is taken
    task automatic send_beat(input logic [BYTE_W-1:0] val, input logic more,
                             input logic typed, input frame_beat_t want);
        @(negedge clk);
        while (!quiet && $urandom_range(99, 0) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= val;
        more_pending <= more;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (pr_in_frame || val == START_MARK)
            useful_beats++;
        predict_rx(val, more);
        if (typed)
            awaited_beats.push_back(want);
        else
            foreach (frame_beats[i])
                awaited_beats.push_back(frame_beats[i]);
    endtask

    task automatic offer_byte(input logic [BYTE_W-1:0] val, input logic more);
        send_beat(val, more, 1'b0, NO_BEAT);
    endtask

    // Stop offering, drain every expected beat, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of the check enable
    task automatic write_crc_en(input logic v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CRC_EN_ADDR;
        pwdata  <= {{(PDATA_W-1){1'b0}}, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pr_crc_en = v;
    endtask

    // One frame with noise before it; CRC byte appended when the check is on
    task automatic send_frame(input int body_len, input logic bad_crc,
                              input logic drop_end, input logic flip_en);
        int                noise_n;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] crc;
        logic              more;
        noise_n = $urandom_range(2, 0);
        for (int i = 0; i < noise_n; i++)
        begin
            b = BYTE_W'($urandom);
            if (b == START_MARK)
                b = b ^ 8'h01;
            offer_byte(b, 1'($urandom_range(1, 0)));
        end
        offer_byte(START_MARK, 1'($urandom_range(1, 0)));
        crc = '0;
        for (int i = 0; i < body_len; i++)
        begin
            b = BYTE_W'($urandom);
            if (b == END_MARK)
                b = ~b;
            crc = crc8_next(crc, b);
            offer_byte(b, 1'($urandom_range(1, 0)));
        end
        // check enable changed mid-frame
        if (flip_en)
        begin
            wait_idle();
            write_crc_en(!pr_crc_en);
        end
        if (drop_end)
            return;
        if (pr_crc_en)
        begin
            if (bad_crc)
                crc = crc ^ BYTE_W'($urandom_range(255, 1));
            if (crc == END_MARK)
            begin
                offer_byte(END_MARK, 1'b1);
                offer_byte(END_MARK, 1'($urandom_range(1, 0)));
            end
            else
            begin
                offer_byte(crc, 1'($urandom_range(1, 0)));
                more = ($urandom_range(3, 0) == 0);
                offer_byte(END_MARK, more);
                if (more)
                begin
                    b = $urandom_range(1, 0) ? END_MARK : BYTE_W'($urandom);
                    offer_byte(b, 1'($urandom_range(1, 0)));
                end
            end
        end
        else
            offer_byte(END_MARK, 1'($urandom_range(1, 0)));
    endtask

    // Receiver side: random stall, quiet stretch, long hold on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= quiet ? 1'b0 : ($urandom_range(99, 0) < 25);
    end

    // Compare each taken output beat with the oldest expectation
    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_beats.size() == 0)
            begin
                $error("unexpected output beat: data_byte %0h frame_last %0b",
                       data_byte, frame_last);
                fail_count++;
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (data_byte !== want.data)
                begin
                    $error("data_byte: expected %0h, actual %0h", want.data, data_byte);
                    fail_count++;
                end
                if (data_valid !== want.valid)
                begin
                    $error("data_valid: expected %0b, actual %0b", want.valid, data_valid);
                    fail_count++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last: expected %0b, actual %0b", want.last, frame_last);
                    fail_count++;
                end
                if (frame_status !== want.status)
                begin
                    $error("frame_status: expected %0b, actual %0b", want.status,
                           frame_status);
                    fail_count++;
                end
                if (payload_length !== want.len)
                begin
                    $error("payload_length: expected %0d, actual %0d", want.len,
                           payload_length);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n_frames;
        int len;
        int pick;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        more_pending = 1'b0;
        out_stall    = 1'b0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        fail_count   = 0;
        cycle_count  = 0;
        useful_beats = 0;
        pr_crc_en    = 1'b0;
        pr_in_frame  = 1'b0;
        pr_wait_end2 = 1'b0;
        pr_count     = 0;
        pr_crc       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            if (SCRIPT[r].kind == ROW_CRC_EN)
            begin
                wait_idle();
                write_crc_en(SCRIPT[r].val[0]);
            end
            else
                send_beat(SCRIPT[r].val, SCRIPT[r].more, SCRIPT[r].typed, SCRIPT[r].want);
        end

        // Random part, in phases with a fresh check setting each
        phase = 0;
        while (useful_beats < TARGET_BEATS)
        begin
            wait_idle();
            quiet = (phase == 2);
            if (phase == 0)
                write_crc_en(1'b0);
            else if (phase == 1)
                write_crc_en(1'b1);
            else
                write_crc_en(1'($urandom_range(1, 0)));
            if (phase == 4)
                hold_req = 1'b1;
            n_frames = $urandom_range(6, 3);
            for (int f = 0; f < n_frames; f++)
            begin
                // mostly short bodies, a few around and past the store size
                pick = $urandom_range(99, 0);
                if (pick < 10)
                begin
                    case ($urandom_range(3, 0))
                        0: len = MAX_BODY - 1;
                        1: len = MAX_BODY;
                        2: len = MAX_BODY + 1;
                        default: len = MAX_BODY + 8;
                    endcase
                end
                else
                    len = $urandom_range(6, 0);
                send_frame(len, $urandom_range(99, 0) < 15, $urandom_range(99, 0) < 5,
                           $urandom_range(99, 0) < 8);
            end
            phase++;
        end
        quiet = 1'b0;

        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/bfr_pkg.sv
rtl/bfr_ram.sv
rtl/bfr_datapath.sv
rtl/bfr_ctrl.sv
rtl/bracket_frame_receiver_crc8_check.sv
tb/sv/tb_bracket_frame_receiver_crc8_check.sv
